// ----- src/idl_pkg.sv -----
`timescale 1ns / 1ps
package idl_pkg;

  localparam int DEPTH_DEF       = 4096;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int POS_W           = 14;
  localparam int FRAC_W          = 16;
  localparam int OP_W            = 3;
  localparam int LEN_W           = 13;
  localparam int LEN_MAX         = 8191;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND   = 3'd0,
    OP_WRITE_AT = 3'd1,
    OP_READ_AT  = 3'd2,
    OP_READ_AGO = 3'd3,
    OP_LINEAR   = 3'd4,
    OP_HERMITE  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRAP,
    ST_READ,
    ST_COEF,
    ST_MUL,
    ST_ACC,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
  } mac_ctl_t;

endpackage

// ----- src/idl_ram.sv -----
`timescale 1ns / 1ps
module idl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/idl_wrap.sv -----
`timescale 1ns / 1ps
module idl_wrap #(
  parameter int PW = 16,
  parameter int AW = 12,
  parameter int LW = 13
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [PW-1:0] operand,
  input  logic [LW-1:0]        len,
  output logic                 done,
  output logic [AW-1:0]        res
);

  localparam int MW = PW - 1;
  localparam int CW = $clog2(MW + 1);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [MW-1:0] mag_r, mag_nxt;
  logic [AW-1:0] rem_r, rem_nxt;
  logic          neg_r, neg_nxt;

  logic signed [PW-1:0] abs_val;
  logic [AW:0]          len_x;
  logic [AW:0]          shifted;
  logic [AW:0]          diff;
  logic [AW:0]          fix;

  assign len_x   = (AW+1)'(len);
  assign shifted = {rem_r, mag_r[MW-1]};
  assign diff    = shifted - len_x;
  assign abs_val = operand[PW-1] ? -operand : operand;
  assign fix     = len_x - (AW+1)'(rem_r);

  assign done = busy_r && (cnt_r == '0);
  assign res  = (neg_r && (rem_r != '0)) ? fix[AW-1:0] : rem_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(MW);
      mag_nxt  = abs_val[MW-1:0];
      rem_nxt  = '0;
      neg_nxt  = operand[PW-1];
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - CW'(1);
        mag_nxt = {mag_r[MW-2:0], 1'b0};
        // one restoring step of the remainder
        rem_nxt = (shifted >= len_x) ? diff[AW-1:0] : shifted[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

endmodule

// ----- src/idl_mac.sv -----
`timescale 1ns / 1ps
module idl_mac import idl_pkg::*; #(
  parameter int ACC_W = 30
) (
  input  logic                    clk,
  input  mac_ctl_t                ctl,
  input  logic signed [ACC_W-1:0] ld_val,
  input  logic [FRAC_W-1:0]       frac,
  input  logic signed [ACC_W-1:0] add_val,
  output logic signed [ACC_W-1:0] acc_out
);

  localparam int PRD_W = ACC_W + FRAC_W + 1;
  localparam logic signed [PRD_W-1:0] HALF = PRD_W'(64'sd1 <<< (FRAC_W - 1));

  logic signed [ACC_W-1:0]  a_r;
  logic signed [PRD_W-1:0]  prod_r;
  logic signed [FRAC_W:0]   t_s;
  logic signed [PRD_W-1:0]  rounded;

  assign t_s     = signed'({1'b0, frac});
  assign rounded = (prod_r + HALF) >>> FRAC_W;
  assign acc_out = a_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r <= ld_val;
    end else if (ctl.acc) begin
      a_r <= ACC_W'(rounded) + add_val;
    end
    if (ctl.mul) begin
      prod_r <= a_r * t_s;
    end
  end

endmodule

// ----- src/interpolating_delay_line.sv -----
`timescale 1ns / 1ps
// Ring buffer of signed Q1.23 audio samples with a programmable active length
// and linear / 4-point Hermite interpolated reads.
// Input channel (in_valid / in_ready) carries one op word: append, write at,
// read at, read ago, linear or hermite, with sample, position and Q0.16
// fraction. Ops that read return one word on the out channel; writes and the
// unused op codes return nothing.
// cfg_active_length may be written while the block is idle; cfg_ready is
// always high. Zero acts as one, values above DEPTH act as DEPTH.
// Each word first runs through a bit-serial modulo unit that wraps the
// position into the ring, one remainder bit per cycle. Then come the memory
// reads (one port, one per cycle) and the shared multiply / round / add unit,
// which does each Horner step as a multiply state and then an accumulate state.
// The block takes a new word only in idle, after the last one has finished.
// After reset the whole store is cleared one entry per cycle with in_ready
// low; the write pointer resets to zero.
// A finished result sits in an output register; if the receiver stalls, the
// block still takes the next word, then waits with that word's result until
// the register is free.
module interpolating_delay_line import idl_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [OP_W-1:0]               in_op,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic signed [POS_W-1:0]       in_position,
  input  logic [FRAC_W-1:0]             in_fraction,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_value_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [LEN_W-1:0]              cfg_active_length
);

  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(DEPTH + 1);
  localparam int PW    = ((AW > POS_W) ? AW : POS_W) + 2;
  localparam int ACC_W = SAMPLE_BITS + 6;
  localparam logic [LEN_W-1:0] LEN_RST = (DEPTH > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(DEPTH);
  localparam logic signed [ACC_W:0] SAT_HI = (ACC_W+1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W:0] SAT_LO = -SAT_HI - (ACC_W+1)'(1);

  state_t state_r, state_nxt;
  logic [LEN_W-1:0] len_r;
  logic [LW-1:0]    len_eff;
  logic [31:0]      len_32;

  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [2:0]    iss_r, iss_nxt;
  logic [2:0]    cap_r, cap_nxt;
  logic [2:0]    rd_total;
  logic          rd_issue;
  logic          rd_vld_r;
  logic [1:0]    step_r, step_nxt;
  logic          out_valid_r, out_valid_nxt;

  op_t                          op_r, op_nxt;
  logic signed [SAMPLE_BITS-1:0] smp_r, smp_nxt;
  logic [FRAC_W-1:0]             frac_r, frac_nxt;
  logic signed [SAMPLE_BITS-1:0] out_data_r, out_data_nxt;
  logic signed [SAMPLE_BITS-1:0] x_r [4];
  logic signed [ACC_W-1:0]       ca_r, cb_r, cc_r, ca_nxt, cb_nxt, cc_nxt;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [SAMPLE_BITS-1:0]        ram_wdata;
  logic [SAMPLE_BITS-1:0]        ram_rdata;

  logic                          wrap_start;
  logic signed [PW-1:0]          wrap_operand;
  logic                          wrap_done;
  logic [AW-1:0]                 wrap_res;
  logic signed [PW-1:0]          pos_ext, wp_ext;

  mac_ctl_t                      mac_ctl;
  logic signed [ACC_W-1:0]       mac_ld, mac_acc;

  logic signed [ACC_W-1:0]       e0, e1, e2, e3;
  logic signed [ACC_W-1:0]       c1, c2, c3, d12;
  logic signed [ACC_W:0]         a_ext, half, v;
  logic signed [SAMPLE_BITS-1:0] v_sat;
  logic [AW:0]                   wrap_inc, addr_inc;
  logic                          accept;

  assign cfg_ready     = 1'b1;
  assign in_ready      = (state_r == ST_IDLE);
  assign accept        = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_value_out = out_data_r;

  always_comb begin
    len_32 = 32'(len_r);
    if (len_32 == 32'd0) begin
      len_32 = 32'd1;
    end else if (len_32 > 32'(DEPTH)) begin
      len_32 = 32'(DEPTH);
    end
    len_eff = LW'(len_32);
  end

  idl_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(addr_r),
    .rdata(ram_rdata)
  );

  idl_wrap #(
    .PW(PW),
    .AW(AW),
    .LW(LW)
  ) u_wrap (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (wrap_start),
    .operand(wrap_operand),
    .len    (len_eff),
    .done   (wrap_done),
    .res    (wrap_res)
  );

  idl_mac #(
    .ACC_W(ACC_W)
  ) u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .ld_val (mac_ld),
    .frac   (frac_r),
    .add_val(ca_r),
    .acc_out(mac_acc)
  );

  // position to wrap, per op
  assign pos_ext = PW'(in_position);
  assign wp_ext  = signed'(PW'(wp_r));

  always_comb begin
    case (op_t'(in_op))
      OP_APPEND:   wrap_operand = wp_ext;
      OP_READ_AGO: wrap_operand = wp_ext - PW'(1) - pos_ext;
      OP_HERMITE:  wrap_operand = pos_ext - PW'(1);
      default:     wrap_operand = pos_ext;
    endcase
  end

  always_comb begin
    case (op_r)
      OP_HERMITE: rd_total = 3'd4;
      OP_LINEAR:  rd_total = 3'd2;
      default:    rd_total = 3'd1;
    endcase
  end

  assign wrap_inc = (AW+1)'(wrap_res) + (AW+1)'(1);
  assign addr_inc = (AW+1)'(addr_r) + (AW+1)'(1);
  assign rd_issue = (state_r == ST_READ) && (iss_r != rd_total);

  // hermite coefficients, twice scaled
  assign e0  = ACC_W'(x_r[0]);
  assign e1  = ACC_W'(x_r[1]);
  assign e2  = ACC_W'(x_r[2]);
  assign e3  = ACC_W'(x_r[3]);
  assign d12 = e1 - e2;
  assign c1  = e2 - e0;
  assign c2  = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
  assign c3  = (e3 - e0) + (d12 <<< 1) + d12;

  // final correction and saturation
  assign a_ext = (ACC_W+1)'(mac_acc);
  assign half  = (a_ext + (ACC_W+1)'(1)) >>> 1;
  assign v     = (op_r == OP_HERMITE) ? ((ACC_W+1)'(e1) + half) : a_ext;

  always_comb begin
    if (v > SAT_HI) begin
      v_sat = SAMPLE_BITS'(SAT_HI);
    end else if (v < SAT_LO) begin
      v_sat = SAMPLE_BITS'(SAT_LO);
    end else begin
      v_sat = SAMPLE_BITS'(v);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    clr_nxt       = clr_r;
    addr_nxt      = addr_r;
    iss_nxt       = iss_r;
    cap_nxt       = cap_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    op_nxt        = op_r;
    smp_nxt       = smp_r;
    frac_nxt      = frac_r;
    ca_nxt        = ca_r;
    cb_nxt        = cb_r;
    cc_nxt        = cc_r;
    ram_we        = 1'b0;
    ram_waddr     = wrap_res;
    ram_wdata     = smp_r;
    wrap_start    = 1'b0;
    mac_ctl       = '0;
    mac_ld        = e3;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          op_nxt   = op_t'(in_op);
          smp_nxt  = in_sample_in;
          frac_nxt = in_fraction;
          case (op_t'(in_op))
            OP_APPEND, OP_WRITE_AT, OP_READ_AT, OP_READ_AGO, OP_LINEAR, OP_HERMITE: begin
              wrap_start = 1'b1;
              state_nxt  = ST_WRAP;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_WRAP: begin
        if (wrap_done) begin
          case (op_r)
            OP_APPEND: begin
              ram_we    = 1'b1;
              wp_nxt    = (wrap_inc == (AW+1)'(len_eff)) ? '0 : wrap_inc[AW-1:0];
              state_nxt = ST_IDLE;
            end
            OP_WRITE_AT: begin
              ram_we    = 1'b1;
              state_nxt = ST_IDLE;
            end
            default: begin
              addr_nxt  = wrap_res;
              iss_nxt   = '0;
              cap_nxt   = '0;
              state_nxt = ST_READ;
            end
          endcase
        end
      end
      ST_READ: begin
        if (rd_issue) begin
          iss_nxt  = iss_r + 3'd1;
          addr_nxt = (addr_inc == (AW+1)'(len_eff)) ? '0 : addr_inc[AW-1:0];
        end
        if (rd_vld_r) begin
          cap_nxt = cap_r + 3'd1;
          if (cap_r + 3'd1 == rd_total) begin
            state_nxt = ST_COEF;
          end
        end
      end
      ST_COEF: begin
        mac_ctl.load = 1'b1;
        case (op_r)
          OP_LINEAR: begin
            mac_ld    = e3 - e2;
            ca_nxt    = e2;
            cb_nxt    = '0;
            cc_nxt    = '0;
            step_nxt  = 2'd1;
            state_nxt = ST_MUL;
          end
          OP_HERMITE: begin
            mac_ld    = c3;
            ca_nxt    = c2;
            cb_nxt    = c1;
            cc_nxt    = '0;
            step_nxt  = 2'd3;
            state_nxt = ST_MUL;
          end
          default: begin
            mac_ld    = e3;
            state_nxt = ST_FIN;
          end
        endcase
      end
      ST_MUL: begin
        mac_ctl.mul = 1'b1;
        state_nxt   = ST_ACC;
      end
      ST_ACC: begin
        mac_ctl.acc = 1'b1;
        ca_nxt      = cb_r;
        cb_nxt      = cc_r;
        cc_nxt      = '0;
        step_nxt    = step_r - 2'd1;
        state_nxt   = (step_r == 2'd1) ? ST_FIN : ST_MUL;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = v_sat;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      len_r       <= LEN_RST;
      wp_r        <= '0;
      clr_r       <= '0;
      iss_r       <= '0;
      cap_r       <= '0;
      step_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      op_r        <= OP_APPEND;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      clr_r       <= clr_nxt;
      iss_r       <= iss_nxt;
      cap_r       <= cap_nxt;
      step_r      <= step_nxt;
      rd_vld_r    <= rd_issue;
      out_valid_r <= out_valid_nxt;
      op_r        <= op_nxt;
      if (cfg_valid && cfg_ready) begin
        len_r <= cfg_active_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    smp_r      <= smp_nxt;
    frac_r     <= frac_nxt;
    out_data_r <= out_data_nxt;
    ca_r       <= ca_nxt;
    cb_r       <= cb_nxt;
    cc_r       <= cc_nxt;
    if (rd_vld_r) begin
      x_r[0] <= x_r[1];
      x_r[1] <= x_r[2];
      x_r[2] <= x_r[3];
      x_r[3] <= signed'(ram_rdata);
    end
  end

  a_wrap_done_in_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    wrap_done |-> (state_r == ST_WRAP))
    else $error("modulo result outside wrap state");

  a_read_data_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_READ))
    else $error("read data returned outside read state");

  a_no_output_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid_r)
    else $error("result presented during clearing pass");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
module tb import idl_pkg::*; ();

  localparam int           SBITS      = SAMPLE_BITS_DEF;
  localparam longint       SMP_MAX    = (longint'(1) <<< (SBITS - 1)) - 1;
  localparam longint       SMP_MIN    = -SMP_MAX - 1;
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int           DRAIN_CYCLES = 40;
  localparam int           HOLD_CYCLES  = 400;

  typedef enum {RX_OPEN, RX_CHOPPY, RX_SPARSE} rx_mode_t;

  class ring_shadow;
    logic signed [SBITS-1:0] ring [DEPTH_DEF];
    logic [11:0]             wr_ptr;
    logic [LEN_W-1:0]        len_reg;
    logic signed [SBITS-1:0] due_values [$];
    int                      mismatches;

    function new();
      foreach (ring[i]) ring[i] = '0;
      wr_ptr     = '0;
      len_reg    = LEN_W'(DEPTH_DEF);
      mismatches = 0;
    endfunction

    function void set_length(logic [LEN_W-1:0] v);
      len_reg = v;
    endfunction

    function int eff_len();
      if (len_reg < 1) return 1;
      if (len_reg > DEPTH_DEF) return DEPTH_DEF;
      return int'(len_reg);
    endfunction

    function int wrap_pos(longint p);
      longint n;
      longint r;
      n = eff_len();
      r = p % n;
      if (r < 0) r += n;
      return int'(r);
    endfunction

    function longint fetch(longint p);
      return longint'(ring[wrap_pos(p)]);
    endfunction

    function longint round_mul(longint a, longint t);
      return (a * t + 32768) >>> 16;
    endfunction

    function void take_word(logic [OP_W-1:0] op, logic signed [SBITS-1:0] smp,
                            logic signed [POS_W-1:0] pos, logic [FRAC_W-1:0] frac);
      longint p, t, v, xm1, x0, x1, x2, c1, c2, c3, a;
      int     n, wp;
      bit     has_result;
      n = eff_len();
      wp = int'(wr_ptr) % n;
      p = pos;
      t = frac;
      v = 0;
      has_result = 1'b1;
      case (op)
        OP_APPEND: begin
          ring[wp] = smp;
          wp++;
          if (wp == n) wp = 0;
          wr_ptr = 12'(wp);
          has_result = 1'b0;
        end
        OP_WRITE_AT: begin
          ring[wrap_pos(p)] = smp;
          has_result = 1'b0;
        end
        OP_READ_AT: v = fetch(p);
        OP_READ_AGO: v = fetch(longint'(wp) - 1 - p);
        OP_LINEAR: begin
          x1 = fetch(p);
          x2 = fetch(p + 1);
          v = x1 + round_mul(x2 - x1, t);
        end
        OP_HERMITE: begin
          xm1 = fetch(p - 1);
          x0  = fetch(p);
          x1  = fetch(p + 1);
          x2  = fetch(p + 2);
          c1 = x1 - xm1;
          c2 = 2 * xm1 - 5 * x0 + 4 * x1 - x2;
          c3 = (x2 - xm1) + 3 * (x0 - x1);
          a = round_mul(c3, t) + c2;
          a = round_mul(a, t) + c1;
          a = round_mul(a, t);
          v = x0 + ((a + 1) >>> 1);
        end
        default: has_result = 1'b0;
      endcase
      if (has_result) begin
        if (v > SMP_MAX) v = SMP_MAX;
        if (v < SMP_MIN) v = SMP_MIN;
        due_values.push_back(SBITS'(v));
      end
    endfunction

    function void match_value(logic signed [SBITS-1:0] got);
      logic signed [SBITS-1:0] want;
      if (due_values.size() == 0) begin
        $error("value_out: expected no word, got %0d", got);
        mismatches++;
        return;
      end
      want = due_values.pop_front();
      if (got !== want) begin
        $error("value_out: expected %0d, got %0d", want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [OP_W-1:0]         in_op = OP_APPEND;
  logic signed [SBITS-1:0] in_sample_in = '0;
  logic signed [POS_W-1:0] in_position = '0;
  logic [FRAC_W-1:0]       in_fraction = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [SBITS-1:0] out_value_out;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [LEN_W-1:0]        cfg_active_length = '0;

  ring_shadow sb = new();
  bit         hold_request = 1'b0;
  int         hold_left = 0;
  int         mode_left = 0;
  rx_mode_t   rx_mode = RX_OPEN;

  interpolating_delay_line dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_sample_in      (in_sample_in),
    .in_position       (in_position),
    .in_fraction       (in_fraction),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_value_out     (out_value_out),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_active_length (cfg_active_length)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // receiver: check accepted words, then pick out_ready for the next cycle
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.match_value(out_value_out);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
          default:   out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_word(input logic [OP_W-1:0] op, input logic signed [SBITS-1:0] smp,
                           input logic signed [POS_W-1:0] pos,
                           input logic [FRAC_W-1:0] frac);
    in_valid     <= 1'b1;
    in_op        <= op;
    in_sample_in <= smp;
    in_position  <= pos;
    in_fraction  <= frac;
    do @(posedge clk); while (!in_ready);
    sb.take_word(op, smp, pos, frac);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] v);
    cfg_valid         <= 1'b1;
    cfg_active_length <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_length(v);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.due_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void pick_word(output logic [OP_W-1:0] op,
                                    output logic signed [SBITS-1:0] smp,
                                    output logic signed [POS_W-1:0] pos,
                                    output logic [FRAC_W-1:0] frac);
    int r, n, lo, hi, wp;
    n  = sb.eff_len();
    wp = int'(sb.wr_ptr) % n;
    r = $urandom_range(0, 99);
    if (r < 24)      op = OP_APPEND;
    else if (r < 38) op = OP_WRITE_AT;
    else if (r < 50) op = OP_READ_AT;
    else if (r < 62) op = OP_READ_AGO;
    else if (r < 78) op = OP_LINEAR;
    else if (r < 96) op = OP_HERMITE;
    else if (r < 98) op = OP_SPARE_LO;
    else             op = OP_SPARE_HI;
    r = $urandom_range(0, 9);
    if (r < 6)      smp = SBITS'($urandom);
    else if (r < 8) smp = $urandom_range(0, 1) ? SBITS'(SMP_MAX) : SBITS'(SMP_MIN);
    else            smp = SBITS'(int'($urandom_range(0, 511)) - 256);
    r = $urandom_range(0, 9);
    if (r < 4) begin
      lo = (2 * n > 8192) ? -8192 : -2 * n;
      hi = (2 * n > 8191) ? 8191 : 2 * n;
      pos = POS_W'(int'($urandom_range(0, hi - lo)) + lo);
    end else if (r < 7) begin
      if (op == OP_READ_AGO) pos = POS_W'($urandom_range(0, 8));
      else pos = POS_W'(wp - int'($urandom_range(1, 6)));
    end else begin
      pos = POS_W'($urandom);
    end
    r = $urandom_range(0, 9);
    if (r < 7)       frac = FRAC_W'($urandom);
    else if (r == 7) frac = '0;
    else if (r == 8) frac = '1;
    else             frac = 16'h8000;
  endfunction

  task automatic run_phase(input int words, input bit steady);
    logic [OP_W-1:0]         op;
    logic signed [SBITS-1:0] smp;
    logic signed [POS_W-1:0] pos;
    logic [FRAC_W-1:0]       frac;
    int                      burst_left;
    int                      gap;
    burst_left = $urandom_range(1, 24);
    for (int i = 0; i < words; i++) begin
      pick_word(op, smp, pos, frac);
      send_word(op, smp, pos, frac);
      burst_left--;
      if (burst_left == 0 && i != words - 1) begin
        burst_left = $urandom_range(1, 24);
        gap = steady ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  task automatic run_directed();
    // store is clear after reset, length still at its reset value
    send_word(OP_READ_AT, '0, 14'sd0, '0);
    send_word(OP_READ_AT, '0, 14'sd4095, '0);
    send_word(OP_APPEND, SBITS'(SMP_MAX), '0, '0);
    send_word(OP_APPEND, SBITS'(SMP_MIN), '0, '0);
    send_word(OP_APPEND, 24'sd1, '0, '0);
    send_word(OP_WRITE_AT, 24'sd12345, -14'sd1, '0);
    send_word(OP_WRITE_AT, -24'sd777, 14'sd8191, '0);
    send_word(OP_READ_AT, '0, 14'sd4095, '0);
    send_word(OP_READ_AT, '0, -14'sd8192, '1);
    send_word(OP_READ_AGO, '0, 14'sd0, '0);
    send_word(OP_READ_AGO, '0, 14'sd2, '0);
    send_word(OP_READ_AGO, '0, 14'sd8191, '0);
    send_word(OP_READ_AGO, '0, -14'sd8192, '0);
    send_word(OP_LINEAR, '0, 14'sd0, '0);
    send_word(OP_LINEAR, '0, 14'sd0, '1);
    send_word(OP_LINEAR, '0, 14'sd4095, 16'h8000);
    send_word(OP_HERMITE, '0, 14'sd0, '0);
    send_word(OP_HERMITE, '0, 14'sd1, '1);
    send_word(OP_HERMITE, '0, 14'sd1, 16'h8000);
    send_word(OP_HERMITE, '0, 14'sd4095, 16'd12345);
    send_word(OP_SPARE_LO, '1, -14'sd1, '1);
    send_word(OP_SPARE_HI, '1, -14'sd1, '1);
    send_word(OP_READ_AT, '0, 14'sd1, '0);
  endtask

  initial begin
    logic [LEN_W-1:0] lengths [$];
    lengths = '{13'd13, 13'd1, 13'd0, 13'd8191, 13'd4097, 13'd2, 13'd5, 13'd4096,
                13'd64, 13'd3000, 13'd7, 13'd0};
    lengths[10] = LEN_W'($urandom_range(3, 40));
    lengths[11] = LEN_W'($urandom);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    settle();
    foreach (lengths[i]) begin
      write_length(lengths[i]);
      // long receiver stall while the sender keeps offering words
      if (i == 6) hold_request = 1'b1;
      run_phase(70, (i % 3 == 0) || (i == 6));
      settle();
    end
    if (sb.mismatches == 0 && sb.due_values.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/idl_pkg.sv
src/idl_ram.sv
src/idl_wrap.sv
src/idl_mac.sv
src/interpolating_delay_line.sv
verif/tb.sv
